// ===== rtl/core/ftbt_pkg.sv =====
package ftbt_pkg;

  localparam int NUM_W       = 31;
  localparam int SYM_W       = 2;
  localparam int MAX_SYMBOLS = 24;
  localparam int NSYM_W      = $clog2(MAX_SYMBOLS);
  localparam int TRIT_DEPTH  = 32;
  localparam int TRIT_IDX_W  = $clog2(TRIT_DEPTH);
  localparam int SHIFT_W     = 5;
  localparam int PROD_W      = 64;

  // floor(x * RECIP3 / 2^33) == x / 3 for any 32-bit x
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

  localparam logic [SYM_W-1:0] SYM_ZERO  = 2'd0;
  localparam logic [SYM_W-1:0] SYM_PLUS  = 2'd1;
  localparam logic [SYM_W-1:0] SYM_MINUS = 2'd2;
  localparam logic [SYM_W-1:0] SYM_POINT = 2'd3;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] den;
    logic             den_zero;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_KMUL,
    ST_KCHK,
    ST_TMUL,
    ST_TCHK,
    ST_EMIT,
    ST_ERR
  } state_t;

endpackage

// ===== rtl/core/ftbt_front.sv =====
module ftbt_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [30:0]           numerator,
  input  logic [30:0]           denominator,
  output logic                  item_valid,
  input  logic                  item_pop,
  output ftbt_pkg::item_t       item
);

  ftbt_pkg::item_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_stall   = (count == 2'd2);
  assign push       = in_valid && !in_stall;
  assign item_valid = (count != 2'd0);
  assign pop        = item_pop && item_valid;
  assign item       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr].num      <= numerator;
      entries[wr_ptr].den      <= denominator;
      entries[wr_ptr].den_zero <= (denominator == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/ftbt_engine.sv =====
module ftbt_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_pop,
  input  ftbt_pkg::item_t       item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            symbol,
  output logic                  last,
  output logic                  error
);

  ftbt_pkg::state_t state, state_next;

  logic [ftbt_pkg::NUM_W-1:0]      a, b, g;
  logic [ftbt_pkg::SHIFT_W-1:0]    sh;
  logic [ftbt_pkg::NUM_W-1:0]      nq, dq, nrem, drem;
  logic [ftbt_pkg::SHIFT_W-1:0]    bitcnt;
  logic [ftbt_pkg::NUM_W-1:0]      x;
  logic [ftbt_pkg::PROD_W-1:0]     prod;
  logic [ftbt_pkg::TRIT_IDX_W-1:0] k, cnt, idx;
  logic [ftbt_pkg::SYM_W-1:0]      trits [ftbt_pkg::TRIT_DEPTH];
  logic                            ptph;
  logic [ftbt_pkg::NSYM_W-1:0]     nsym;

  logic                            slot_free;
  logic                            gcd_done;
  logic [ftbt_pkg::NUM_W-1:0]      q3;
  logic [31:0]                     r3_full;
  logic [1:0]                      r3;
  logic [ftbt_pkg::NUM_W:0]        nrem_sh, drem_sh, nrem_sub, drem_sub;
  logic                            emit_last;
  logic [ftbt_pkg::SYM_W-1:0]      emit_sym;

  assign slot_free = !out_valid || !out_stall;
  assign gcd_done  = (a == '0) || (b == '0);
  assign q3        = prod[63:33];
  assign r3_full   = {1'b0, x} - ({q3, 1'b0} + {1'b0, q3});
  assign r3        = r3_full[1:0];

  assign nrem_sh  = {nrem, nq[ftbt_pkg::NUM_W-1]};
  assign drem_sh  = {drem, dq[ftbt_pkg::NUM_W-1]};
  assign nrem_sub = nrem_sh - {1'b0, g};
  assign drem_sub = drem_sh - {1'b0, g};

  assign emit_sym  = ptph ? ftbt_pkg::SYM_POINT : trits[idx];
  assign emit_last = (!ptph && (idx == '0)) ||
                     (nsym == ftbt_pkg::NSYM_W'(ftbt_pkg::MAX_SYMBOLS - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ftbt_pkg::ST_IDLE:
        if (item_valid) state_next = item.den_zero ? ftbt_pkg::ST_ERR : ftbt_pkg::ST_GCD;
      ftbt_pkg::ST_GCD:
        if (gcd_done) state_next = ftbt_pkg::ST_DIV;
      ftbt_pkg::ST_DIV:
        if (bitcnt == '0) state_next = ftbt_pkg::ST_KMUL;
      ftbt_pkg::ST_KMUL:
        state_next = ftbt_pkg::ST_KCHK;
      ftbt_pkg::ST_KCHK:
        if (r3 == 2'd0)  state_next = ftbt_pkg::ST_KMUL;
        else if (x == ftbt_pkg::NUM_W'(1)) state_next = ftbt_pkg::ST_TMUL;
        else             state_next = ftbt_pkg::ST_ERR;
      ftbt_pkg::ST_TMUL:
        state_next = (x == '0) ? ftbt_pkg::ST_EMIT : ftbt_pkg::ST_TCHK;
      ftbt_pkg::ST_TCHK:
        state_next = ftbt_pkg::ST_TMUL;
      ftbt_pkg::ST_EMIT:
        if (slot_free && emit_last) state_next = ftbt_pkg::ST_IDLE;
      ftbt_pkg::ST_ERR:
        if (slot_free) state_next = ftbt_pkg::ST_IDLE;
      default:
        state_next = ftbt_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    item_pop = 1'b0;
    unique case (state)
      ftbt_pkg::ST_IDLE: item_pop = item_valid;
      default:           item_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ftbt_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ftbt_pkg::ST_IDLE: begin
        a      <= item.num;
        b      <= item.den;
        sh     <= '0;
        nq     <= item.num;
        dq     <= item.den;
        nrem   <= '0;
        drem   <= '0;
        bitcnt <= ftbt_pkg::SHIFT_W'(ftbt_pkg::NUM_W - 1);
        k      <= '0;
        cnt    <= '0;
        ptph   <= 1'b0;
        nsym   <= '0;
        for (int i = 0; i < ftbt_pkg::TRIT_DEPTH; i++) trits[i] <= ftbt_pkg::SYM_ZERO;
      end
      ftbt_pkg::ST_GCD: begin
        if (gcd_done) begin
          g <= ((a == '0) ? b : a) << sh;
        end else if (!a[0] && !b[0]) begin
          a  <= a >> 1;
          b  <= b >> 1;
          sh <= sh + 1'b1;
        end else if (!a[0]) begin
          a <= a >> 1;
        end else if (!b[0]) begin
          b <= b >> 1;
        end else if (a >= b) begin
          a <= a - b;
        end else begin
          b <= b - a;
        end
      end
      ftbt_pkg::ST_DIV: begin
        // one restoring step on both quotients
        if (!nrem_sub[ftbt_pkg::NUM_W]) begin
          nrem <= nrem_sub[ftbt_pkg::NUM_W-1:0];
          nq   <= {nq[ftbt_pkg::NUM_W-2:0], 1'b1};
        end else begin
          nrem <= nrem_sh[ftbt_pkg::NUM_W-1:0];
          nq   <= {nq[ftbt_pkg::NUM_W-2:0], 1'b0};
        end
        if (!drem_sub[ftbt_pkg::NUM_W]) begin
          drem <= drem_sub[ftbt_pkg::NUM_W-1:0];
          dq   <= {dq[ftbt_pkg::NUM_W-2:0], 1'b1};
        end else begin
          drem <= drem_sh[ftbt_pkg::NUM_W-1:0];
          dq   <= {dq[ftbt_pkg::NUM_W-2:0], 1'b0};
        end
        bitcnt <= bitcnt - 1'b1;
        if (bitcnt == '0) x <= drem_sub[ftbt_pkg::NUM_W] ?
                                {dq[ftbt_pkg::NUM_W-2:0], 1'b0} :
                                {dq[ftbt_pkg::NUM_W-2:0], 1'b1};
      end
      ftbt_pkg::ST_KMUL, ftbt_pkg::ST_TMUL: begin
        prod <= ftbt_pkg::PROD_W'({1'b0, x}) * ftbt_pkg::PROD_W'(ftbt_pkg::RECIP3);
        if (state == ftbt_pkg::ST_TMUL && x == '0) begin
          idx <= (cnt > k) ? cnt - 1'b1 : k;
        end
      end
      ftbt_pkg::ST_KCHK: begin
        if (r3 == 2'd0) begin
          x <= q3;
          k <= k + 1'b1;
        end else begin
          x <= nq;
        end
      end
      ftbt_pkg::ST_TCHK: begin
        trits[cnt] <= r3;
        cnt        <= cnt + 1'b1;
        x          <= q3 + ftbt_pkg::NUM_W'(r3 == 2'd2);
      end
      ftbt_pkg::ST_EMIT: begin
        if (slot_free) begin
          nsym <= nsym + 1'b1;
          if (ptph) begin
            ptph <= 1'b0;
            idx  <= idx - 1'b1;
          end else if ((k != '0) && (idx == k)) begin
            ptph <= 1'b1;
          end else begin
            idx <= idx - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= (state == ftbt_pkg::ST_EMIT) || (state == ftbt_pkg::ST_ERR);
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (state == ftbt_pkg::ST_ERR) begin
        symbol <= ftbt_pkg::SYM_ZERO;
        last   <= 1'b1;
        error  <= 1'b1;
      end else if (state == ftbt_pkg::ST_EMIT) begin
        symbol <= emit_sym;
        last   <= emit_last;
        error  <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/fraction_to_balanced_ternary_core.sv =====
// Steps: take an item, reduce it by binary GCD, divide numerator and denominator by the
//   GCD with a restoring divider, strip factors of three from the denominator, extract
//   trits, then emit the symbols through the output register.
// Throughput: one item per conversion, set by the iterative GCD, divider and shared
//   divide-by-three unit; symbols then leave one per cycle while out_stall is low.
// Reset (rst, synchronous, active high) empties the two-entry input queue and drops any
//   conversion in flight; no state carries over between items.
module fraction_to_balanced_ternary_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [30:0] numerator,
  input  logic [30:0] denominator,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  symbol,
  output logic        last,
  output logic        error
);

  ftbt_pkg::item_t item;
  logic            item_valid;
  logic            item_pop;

  // front: hold up to two items, flag a zero denominator up front
  ftbt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .numerator   (numerator),
    .denominator (denominator),
    .item_valid  (item_valid),
    .item_pop    (item_pop),
    .item        (item)
  );

  // back: reduce, test for a power of three, extract trits, emit symbols
  ftbt_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .item       (item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .symbol     (symbol),
    .last       (last),
    .error      (error)
  );

endmodule

// ===== rtl/core/ftbt_checker.sv =====
module ftbt_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] symbol,
  input logic       last,
  input logic       error
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(symbol) && $stable(last) && $stable(error))
    else $error("stalled result changed");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> last && (symbol == ftbt_pkg::SYM_ZERO))
    else $error("error result malformed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_err_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> !(out_valid && error))
    else $error("error result inside a conversion");

endmodule

bind fraction_to_balanced_ternary_core ftbt_checker u_ftbt_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .symbol    (symbol),
  .last      (last),
  .error     (error)
);
